// File: hdl/cet_pkg.sv
package cet_pkg;

   localparam int NUM_SLOTS_DEF = 16;

   localparam int ACTION_W   = 3;
   localparam int REF_W      = 16;
   localparam int DUR_W      = 16;
   localparam int SLOT_IN_W  = 4;
   localparam int COUNT_W    = 24;
   localparam int TPU_W      = 9;
   localparam int PROD_W     = DUR_W + TPU_W;

   localparam logic [TPU_W-1:0]   TPU_RESET = 9'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // ram word: ref [15:0], count [39:16], done [40]
   localparam int WORD_W = REF_W + COUNT_W + 1;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = ACTION_W;
   localparam int RSP_DATA_W = REF_W;
   localparam int RSP_USER_W = 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_TICK   = 3'd1,
      ACT_NEXT   = 3'd2,
      ACT_FORGET = 3'd3,
      ACT_FLUSH  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_PUSH,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/countdown_event_table.sv
// Channel | Ports     | Contents
// req     | req_t*    | tuser: action[2:0]; tdata: event_ref, duration, slot
// rsp     | rsp_t*    | tuser: found[0]; tdata: done_ref[15:0]
// csr     | csr_*     | ticks_per_unit[8:0], always ready
//
// One transaction at a time. Push goes from accept through decode, multiply, then one
// ram write to the result; tick and next sweep every slot through the single ram read
// port, one slot a cycle; forget, flush and others go from decode to the result.
// The next request can be taken in the same cycle as the result goes valid.
// Synchronous reset clears all slots to inactive through per-slot valid flops.
// A result waiting on rsp_tready does not block the next request.
module countdown_event_table
   import cet_pkg::*;
#(
   parameter int NUM_SLOTS = cet_pkg::NUM_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // event_ref[15:0], duration[31:16], slot[35:32], zero pad
   input  logic [cet_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[2:0]
   input  logic [cet_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // done_ref[15:0]
   output logic [cet_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found[0]
   output logic [cet_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cet_pkg::TPU_W-1:0]      csr_data
);

   import cet_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_SLOTS);
   localparam logic [SLOT_IN_W+PTR_W-1:0] SLOT_LIM = (SLOT_IN_W + PTR_W)'(NUM_SLOTS);

   state_type state_ff, state_in;

   logic [TPU_W-1:0]     tpu_ff;
   logic [ACTION_W-1:0]  act_ff;
   logic [REF_W-1:0]     ref_ff;
   logic [DUR_W-1:0]     dur_ff;
   logic [SLOT_IN_W-1:0] slot_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PTR_W-1:0]     wp_ff;
   logic [PTR_W-1:0]     cnt_ff;
   logic                 pend_ff;
   logic [SLOT_W-1:0]    pidx_ff;
   logic [NUM_SLOTS-1:0] vld_ff;
   logic                 res_found_ff;
   logic [REF_W-1:0]     res_ref_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [REF_W-1:0]     rsp_ref_ff;

   logic                 req_fire;
   logic                 rsp_free;
   logic [PTR_W-1:0]     wp_eff;
   logic [COUNT_W-1:0]   sat_count;
   logic                 rd_en;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    rd_data;
   logic                 e_done;
   logic [COUNT_W-1:0]   e_count;
   logic [REF_W-1:0]     e_ref;
   logic                 tick_hit;
   logic                 next_hit;
   logic                 forget_ok;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign wp_eff    = (wp_ff >= LAST_PTR) ? '0 : wp_ff;
   assign sat_count = prod_ff[PROD_W-1] ? COUNT_MAX : prod_ff[COUNT_W-1:0];

   assign e_ref   = rd_data[REF_W-1:0];
   assign e_count = rd_data[REF_W+COUNT_W-1:REF_W];
   assign e_done  = rd_data[WORD_W-1];

   assign tick_hit  = (state_ff == ST_SCAN) && pend_ff && (act_ff == ACT_TICK)
                      && vld_ff[pidx_ff] && !e_done;
   assign next_hit  = (state_ff == ST_SCAN) && pend_ff && (act_ff == ACT_NEXT)
                      && vld_ff[pidx_ff] && e_done && !res_found_ff;
   assign forget_ok = ({{PTR_W{1'b0}}, slot_ff} < SLOT_LIM);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (act_ff)
               ACT_PUSH: state_in = ST_MUL;
               ACT_TICK, ACT_NEXT: state_in = ST_SCAN;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_MUL:  state_in = ST_PUSH;
         ST_PUSH: state_in = ST_FINISH;
         ST_SCAN: begin
            if (cnt_ff == LAST_PTR && !pend_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rd_en      = 1'b0;
      rd_addr    = cnt_ff[SLOT_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = pidx_ff;
      wr_data    = {e_count == '0, e_count - 1'b1, e_ref};
      case (state_ff)
         ST_SCAN: begin
            rd_en = (cnt_ff != LAST_PTR);
            wr_en = tick_hit;
         end
         ST_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = wp_eff[SLOT_W-1:0];
            wr_data = {1'b0, sat_count, ref_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   cet_ram #(
      .WIDTH(WORD_W),
      .DEPTH(NUM_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tpu_ff       <= TPU_RESET;
         wp_ff        <= '0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            tpu_ff <= csr_data;
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         pend_ff <= rd_en;
         case (state_ff)
            ST_DECODE: begin
               if (act_ff == ACT_FORGET && forget_ok) begin
                  vld_ff[SLOT_W'(slot_ff)] <= 1'b0;
               end
               if (act_ff == ACT_FLUSH) begin
                  vld_ff <= '0;
                  wp_ff  <= '0;
               end
            end
            ST_PUSH: begin
               vld_ff[wp_eff[SLOT_W-1:0]] <= 1'b1;
               wp_ff <= wp_eff + 1'b1;
            end
            ST_SCAN: begin
               if (next_hit) begin
                  vld_ff[pidx_ff] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_tuser;
         ref_ff  <= req_tdata[REF_W-1:0];
         dur_ff  <= req_tdata[REF_W+DUR_W-1:REF_W];
         slot_ff <= req_tdata[REF_W+DUR_W+SLOT_IN_W-1:REF_W+DUR_W];
      end
      if (state_ff == ST_DECODE) begin
         cnt_ff       <= '0;
         res_found_ff <= 1'b0;
         res_ref_ff   <= '0;
      end
      if (rd_en) begin
         cnt_ff  <= cnt_ff + 1'b1;
         pidx_ff <= cnt_ff[SLOT_W-1:0];
      end
      if (next_hit) begin
         res_found_ff <= 1'b1;
         res_ref_ff   <= e_ref;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(dur_ff) * PROD_W'(tpu_ff);
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_found_ff <= res_found_ff;
         rsp_ref_ff   <= res_ref_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ref_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// File: hdl/cet_ram.sv
module cet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cet_checker.sv
module cet_checker
   import cet_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cet_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [cet_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import cet_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("reference nonzero without found");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind countdown_event_table cet_checker u_cet_checker (.*);
